### rtl/lcfs_pkg.sv
// lcfs_pkg: shared types and constants of the light channel fade/strobe engine.
// No dependencies; imported by every module of the block.
package lcfs_pkg;

  localparam int unsigned LEVEL_W     = 8;
  localparam int unsigned CH_W        = 4;
  localparam int unsigned TICK_W      = 16;
  localparam int unsigned SEC_W       = 8;
  localparam int unsigned LEN_W       = 18;   // up to 255000 ms
  localparam int unsigned ELAPSED_W   = 19;
  localparam int unsigned NUM_W       = 26;   // dividend, always below 256 * length
  localparam int unsigned QUO_BITS    = 8;
  localparam int unsigned DIV_CNT_W   = $clog2(QUO_BITS + 1);
  localparam int unsigned STORE_DEPTH = 16;
  localparam int unsigned STORE_AW    = 4;
  localparam int unsigned MS_PER_SEC  = 1000;

  typedef enum logic [1:0] {
    REQ_LOAD_START  = 2'd0,
    REQ_LOAD_TARGET = 2'd1,
    REQ_BEGIN       = 2'd2,
    REQ_TICK        = 2'd3
  } req_e;

  typedef enum logic {
    CFG_MODE     = 1'b0,
    CFG_FADE_SEC = 1'b1
  } cfg_e;

  typedef enum logic {
    MODE_FADE   = 1'b0,
    MODE_STROBE = 1'b1
  } mode_e;

  typedef enum logic [1:0] {
    FR_FADE   = 2'd0,
    FR_DARK   = 2'd1,
    FR_TARGET = 2'd2,
    FR_START  = 2'd3
  } frame_e;

  typedef enum logic [2:0] {
    ST_IDLE = 3'd0,
    ST_READ = 3'd1,
    ST_MUL  = 3'd2,
    ST_LOAD = 3'd3,
    ST_DIV  = 3'd4,
    ST_EMIT = 3'd5,
    ST_STEP = 3'd6
  } state_e;

  // level store write request
  typedef struct packed {
    logic                we_start;
    logic                we_target;
    logic [STORE_AW-1:0] addr;
    logic [LEVEL_W-1:0]  data;
  } lcfs_wr_t;

endpackage

### rtl/light_channel_fade_strobe.sv
// light_channel_fade_strobe: top level of the per-channel fade/strobe engine.
// Depends on lcfs_pkg, lcfs_store and lcfs_div.
//
// Command-style block. A request is taken when start_i is high and busy_o is low.
// Load and begin requests finish in the accepting cycle and never raise busy_o.
// A tick while a transition runs raises busy_o and emits one frame of CHANNELS
// results, one per strobe on out_valid_o; results cannot be held off, so the
// receiver must take each one in its cycle. Strobes never come in adjacent
// cycles. In fade mode each channel walks read, multiply, divider load, eight
// divider steps and emit in turn, using the single shared restoring divider.
// Strobe frames and closing frames walk read, multiply and emit for each
// channel. After a tick's first frame a step state adds the tick time to the
// elapsed total and decides whether a closing frame (transition_done_o set)
// follows at once. Register writes on the cfg port take effect at the next begin;
// loads during a transition are seen by later frames. Store entries must be
// loaded before a transition reads them.
module light_channel_fade_strobe
  import lcfs_pkg::*;
#(
  parameter int unsigned CHANNELS = 16
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  // request channel
  input  logic                start_i,
  output logic                busy_o,
  input  logic [1:0]          req_type_i,
  input  logic [CH_W-1:0]     channel_i,
  input  logic [LEVEL_W-1:0]  level_i,
  input  logic [TICK_W-1:0]   tick_ms_i,
  // configuration write port
  input  logic                cfg_we_i,
  input  logic                cfg_idx_i,
  input  logic [SEC_W-1:0]    cfg_data_i,
  // result strobe
  output logic                out_valid_o,
  output logic [CH_W-1:0]     out_channel_o,
  output logic [LEVEL_W-1:0]  out_level_o,
  output logic                frame_last_o,
  output logic                transition_done_o
);

  localparam int unsigned CNT_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam int unsigned EXT_W = 6;  // holds any channel count up to 32

  state_e state_q, state_d;

  // configuration and latched transition settings
  mode_e                mode_q, mode_lat_q;
  logic [SEC_W-1:0]     fsec_q;
  logic [LEN_W-1:0]     len_q;
  logic [LEN_W-1:0]     len_begin;

  // transition progress
  logic [ELAPSED_W-1:0] elapsed_q;
  logic [ELAPSED_W-1:0] elapsed_sum;
  logic                 running_q;
  logic                 dark_q;
  logic                 closing_q;
  logic                 reach_end;
  frame_e               kind_q;
  logic [TICK_W-1:0]    tick_q;
  logic [CNT_W-1:0]     ch_q;
  logic [EXT_W-1:0]     ch_ext;
  logic                 ch_last;

  // datapath
  logic [NUM_W-1:0]     prod_s_q;     // start * length
  logic signed [28:0]   prod_d_q;     // (target - start) * elapsed
  logic signed [8:0]    diff;
  logic signed [19:0]   elapsed_s;
  logic signed [28:0]   num_s;
  logic [LEVEL_W-1:0]   lvl_q;
  logic [LEVEL_W-1:0]   start_rd, target_rd;
  logic                 div_start, div_done;
  logic [QUO_BITS-1:0]  div_quo;

  logic                 accept;
  req_e                 req;
  logic                 ch_in_range;
  lcfs_wr_t             wr;

  assign req         = req_e'(req_type_i);
  assign accept      = start_i && !busy_o;
  assign ch_in_range = ({2'b00, channel_i} < EXT_W'(CHANNELS));
  assign ch_ext      = EXT_W'(ch_q);
  assign ch_last     = (ch_q == CNT_W'(CHANNELS - 1));

  // zero seconds counts as one
  assign len_begin = LEN_W'((fsec_q == '0) ? SEC_W'(1) : fsec_q) * LEN_W'(MS_PER_SEC);

  assign elapsed_sum = elapsed_q + ELAPSED_W'(tick_q);
  assign reach_end   = (elapsed_sum >= ELAPSED_W'(len_q));

  always_comb begin
    wr.we_start  = accept && (req == REQ_LOAD_START) && ch_in_range;
    wr.we_target = accept && (req == REQ_LOAD_TARGET) && ch_in_range;
    wr.addr      = channel_i;
    wr.data      = level_i;
  end

  lcfs_store u_store (
    .clk_i       (clk_i),
    .wr_i        (wr),
    .raddr_i     (ch_ext[STORE_AW-1:0]),
    .start_rd_o  (start_rd),
    .target_rd_o (target_rd)
  );

  // dividend = start*len + (target-start)*elapsed, nonnegative since elapsed < len
  assign num_s = $signed({3'b000, prod_s_q}) + prod_d_q;

  lcfs_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .num_i   (num_s[NUM_W-1:0]),
    .len_i   (len_q),
    .done_o  (div_done),
    .quo_o   (div_quo)
  );

  assign diff      = $signed({1'b0, target_rd}) - $signed({1'b0, start_rd});
  assign elapsed_s = $signed({1'b0, elapsed_q});

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (accept && (req == REQ_TICK) && running_q) begin
          state_d = ST_READ;
        end
      end
      ST_READ: state_d = ST_MUL;
      ST_MUL:  state_d = (kind_q == FR_FADE) ? ST_LOAD : ST_EMIT;
      ST_LOAD: state_d = ST_DIV;
      ST_DIV: begin
        if (div_done) begin
          state_d = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (!ch_last) begin
          state_d = ST_READ;
        end else if (closing_q) begin
          state_d = ST_IDLE;
        end else begin
          state_d = ST_STEP;
        end
      end
      ST_STEP: state_d = reach_end ? ST_READ : ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  // state outputs
  always_comb begin
    busy_o      = 1'b1;
    out_valid_o = 1'b0;
    div_start   = 1'b0;
    case (state_q)
      ST_IDLE: busy_o      = 1'b0;
      ST_LOAD: div_start   = 1'b1;
      ST_EMIT: out_valid_o = 1'b1;
      default: ;
    endcase
  end

  assign out_channel_o     = ch_ext[CH_W-1:0];
  assign out_level_o       = lvl_q;
  assign frame_last_o      = ch_last;
  assign transition_done_o = closing_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_IDLE;
      mode_q     <= MODE_FADE;
      fsec_q     <= SEC_W'(1);
      len_q      <= LEN_W'(MS_PER_SEC);
      mode_lat_q <= MODE_FADE;
      elapsed_q  <= '0;
      running_q  <= 1'b0;
      dark_q     <= 1'b1;
      closing_q  <= 1'b0;
      kind_q     <= FR_FADE;
      ch_q       <= '0;
    end else begin
      state_q <= state_d;

      if (cfg_we_i) begin
        case (cfg_e'(cfg_idx_i))
          CFG_MODE:     mode_q <= mode_e'(cfg_data_i[0]);
          CFG_FADE_SEC: fsec_q <= cfg_data_i;
          default: ;
        endcase
      end

      if (accept && (req == REQ_BEGIN)) begin
        len_q      <= len_begin;
        mode_lat_q <= mode_q;
        elapsed_q  <= '0;
        dark_q     <= 1'b1;
        running_q  <= 1'b1;
      end

      // tick: first frame of the tick
      if (accept && (req == REQ_TICK) && running_q) begin
        ch_q      <= '0;
        closing_q <= 1'b0;
        if (mode_lat_q == MODE_FADE) begin
          kind_q <= FR_FADE;
        end else begin
          kind_q <= dark_q ? FR_DARK : FR_TARGET;
          dark_q <= !dark_q;
        end
      end

      if ((state_q == ST_EMIT) && !ch_last) begin
        ch_q <= ch_q + 1'b1;
      end

      // advance time; closing frame if the length is reached
      if (state_q == ST_STEP) begin
        elapsed_q <= elapsed_sum;
        if (reach_end) begin
          running_q <= 1'b0;
          closing_q <= 1'b1;
          ch_q      <= '0;
          kind_q    <= (mode_lat_q == MODE_FADE) ? FR_TARGET : FR_START;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      tick_q <= tick_ms_i;
    end
    if (state_q == ST_MUL) begin
      prod_s_q <= NUM_W'(start_rd) * NUM_W'(len_q);
      prod_d_q <= diff * elapsed_s;
      case (kind_q)
        FR_DARK:   lvl_q <= '0;
        FR_TARGET: lvl_q <= target_rd;
        FR_START:  lvl_q <= start_rd;
        default:   lvl_q <= lvl_q;
      endcase
    end
    if ((state_q == ST_DIV) && div_done) begin
      lvl_q <= div_quo;
    end
  end

endmodule

### rtl/lcfs_store.sv
// lcfs_store: start and target level memories, one write port, registered read.
// Depends on lcfs_pkg.
module lcfs_store
  import lcfs_pkg::*;
(
  input  logic                clk_i,
  input  lcfs_wr_t            wr_i,
  input  logic [STORE_AW-1:0] raddr_i,
  output logic [LEVEL_W-1:0]  start_rd_o,
  output logic [LEVEL_W-1:0]  target_rd_o
);

  logic [LEVEL_W-1:0] start_mem  [STORE_DEPTH];
  logic [LEVEL_W-1:0] target_mem [STORE_DEPTH];

  always_ff @(posedge clk_i) begin
    if (wr_i.we_start) begin
      start_mem[wr_i.addr] <= wr_i.data;
    end
    if (wr_i.we_target) begin
      target_mem[wr_i.addr] <= wr_i.data;
    end
  end

  always_ff @(posedge clk_i) begin
    start_rd_o  <= start_mem[raddr_i];
    target_rd_o <= target_mem[raddr_i];
  end

endmodule

### rtl/lcfs_div.sv
// lcfs_div: restoring divider, one quotient bit per cycle, 8-bit quotient.
// Depends on lcfs_pkg.
module lcfs_div
  import lcfs_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start_i,
  input  logic [NUM_W-1:0]    num_i,
  input  logic [LEN_W-1:0]    len_i,
  output logic                done_o,
  output logic [QUO_BITS-1:0] quo_o
);

  logic [NUM_W-1:0]     rem_q, rem_d;
  logic [NUM_W-1:0]     dvs_q, dvs_d;
  logic [QUO_BITS-1:0]  quo_q, quo_d;
  logic [DIV_CNT_W-1:0] cnt_q, cnt_d;
  logic                 fit;

  assign fit = (rem_q >= dvs_q);

  always_comb begin
    rem_d = rem_q;
    dvs_d = dvs_q;
    quo_d = quo_q;
    cnt_d = cnt_q;
    if (start_i) begin
      rem_d = num_i;
      dvs_d = NUM_W'(len_i) << (QUO_BITS - 1);
      quo_d = '0;
      cnt_d = DIV_CNT_W'(QUO_BITS);
    end else if (cnt_q != '0) begin
      rem_d = fit ? (rem_q - dvs_q) : rem_q;
      dvs_d = dvs_q >> 1;
      quo_d = {quo_q[QUO_BITS-2:0], fit};
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    dvs_q <= dvs_d;
    quo_q <= quo_d;
  end

  assign done_o = (cnt_q == '0);
  assign quo_o  = quo_q;

endmodule

### rtl/lcfs_checker.sv
// lcfs_checker: port-level assertions for light_channel_fade_strobe, with bind.
// Depends on lcfs_pkg; attaches to the top level.
module lcfs_checker
  import lcfs_pkg::*;
(
  input logic       clk_i,
  input logic       rst_ni,
  input logic       start_i,
  input logic       busy_o,
  input logic [1:0] req_type_i,
  input logic       out_valid_o,
  input logic       frame_last_o,
  input logic       transition_done_o
);

  // a result transfer only happens while a tick is being worked on
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> busy_o)
    else $error("result strobe while idle");

  // channels of one frame never come in adjacent cycles
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !frame_last_o) |=> !out_valid_o)
    else $error("back-to-back result strobes inside a frame");

  // begin never occupies the block
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && !busy_o && (req_type_i == REQ_BEGIN)) |=> !busy_o)
    else $error("begin request left the block busy");

  // the last transfer of a closing frame frees the block
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && frame_last_o && transition_done_o) |=> !busy_o)
    else $error("block still busy after closing frame");

endmodule

bind light_channel_fade_strobe lcfs_checker u_lcfs_checker (
  .clk_i             (clk_i),
  .rst_ni            (rst_ni),
  .start_i           (start_i),
  .busy_o            (busy_o),
  .req_type_i        (req_type_i),
  .out_valid_o       (out_valid_o),
  .frame_last_o      (frame_last_o),
  .transition_done_o (transition_done_o)
);
